>>> rtl/core/rpfs_pkg.sv
// ----------------------------------------------------------------------------
// rpfs_pkg
// Shared types and constants of the row packet frame store.
// ----------------------------------------------------------------------------
package rpfs_pkg;

   // packet header characters
   localparam logic [7:0] SYNC_CHAR  = 8'h59;  // 'Y'
   localparam logic [7:0] COLON_CHAR = 8'h3A;  // ':'
   localparam int unsigned HDR_LEN   = 3;

   // display rotation codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FLUSH,
      ST_READ
   } state_type;

   typedef struct packed {
      logic accept;     // request transfer this cycle
      logic clear_wr;   // write zero at sweep address
      logic flush_wr;   // copy one row byte to the frame store
      logic cnt_clr;
      logic cnt_inc;
      logic set_valid;  // response register becomes valid
      logic pix_load;   // capture pixel from frame store read data
   } cmd_type;

   typedef struct packed {
      logic item_read;      // request is a pixel read
      logic pkt_done;       // request byte completes a row packet
      logic cnt_row_last;
      logic cnt_frame_last;
      logic rsp_valid;
   } status_type;

endpackage

>>> rtl/core/row_packet_frame_store.sv
// ----------------------------------------------------------------------------
// row_packet_frame_store
// Row packet receiver with a 1-bit frame store and rotated pixel readout.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: req_tuser = 0 gives a link byte,
//   req_tuser = 1 a pixel read. Link bytes form packets 'Y', ':', row
//   number, then ROW_BYTES pixel bytes; a complete row is copied into the
//   frame store at row * ROW_BYTES (rows past the end go to row 0).
//   rsp_* returns exactly one result per request, in request order.
//   csr_wen/csr_wdata write the display rotation (0/90/180/270 degrees);
//   write it only while no request is in flight.
// Sequencing / throughput:
//   ordinary link byte: result registered in the cycle after the request transfer.
//   pixel read: read state, then response register (registered frame store read port).
//   row-completing byte: flush state, then response register; one byte copied per cycle
//   through the single frame store write port.
//   One item is in flight at a time; the next request is taken once the
//   response register has been emptied.
// Reset:
//   synchronous; afterwards the frame store is zeroed by a sweep over all
//   FRAME_BYTES addresses during which req_tready stays low.
// Stall: a stalled response holds its data; req_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module row_packet_frame_store #(
   parameter int ROW_BYTES   = 16,   // 1 .. 64
   parameter int FRAME_BYTES = 1024  // 16 .. 4096
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wen,
   input  logic [1:0]  csr_wdata,   // rotation
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // rx_byte[7:0], pix_x[14:8], pix_y[20:15]
   input  logic        req_tuser,   // action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // row_written[0], link_up[1], screen_x[8:2],
                                    // screen_y[15:9], pixel_on[16]
);

   rpfs_pkg::cmd_type    cmd;
   rpfs_pkg::status_type status;

   // controller: sweep, accept, flush and read sequencing
   rpfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: parser, row buffer, frame store, rotation, response register
   rpfs_dp #(
      .ROW_BYTES   (ROW_BYTES),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

   assign rsp_tvalid = status.rsp_valid;

endmodule

>>> rtl/core/rpfs_ram.sv
// ----------------------------------------------------------------------------
// rpfs_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module rpfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rpfs_ctrl.sv
// ----------------------------------------------------------------------------
// rpfs_ctrl
// Sequencer: post-reset clear sweep, request acceptance, row flush, pixel read.
// ----------------------------------------------------------------------------
module rpfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rpfs_pkg::status_type status,
   output rpfs_pkg::cmd_type    cmd
);

   rpfs_pkg::state_type state_ff;
   rpfs_pkg::state_type state_in;
   logic                accept;

   assign req_tready = (state_ff == rpfs_pkg::ST_IDLE) && !status.rsp_valid;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpfs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpfs_pkg::ST_CLEAR: begin
            if (status.cnt_frame_last) state_in = rpfs_pkg::ST_IDLE;
         end
         rpfs_pkg::ST_IDLE: begin
            if (accept && status.item_read) begin
               state_in = rpfs_pkg::ST_READ;
            end else if (accept && status.pkt_done) begin
               state_in = rpfs_pkg::ST_FLUSH;
            end
         end
         rpfs_pkg::ST_FLUSH: begin
            if (status.cnt_row_last) state_in = rpfs_pkg::ST_IDLE;
         end
         rpfs_pkg::ST_READ: begin
            state_in = rpfs_pkg::ST_IDLE;
         end
         default: state_in = rpfs_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.accept = accept;
      unique case (state_ff)
         rpfs_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.cnt_inc  = 1'b1;
         end
         rpfs_pkg::ST_IDLE: begin
            cmd.cnt_clr   = 1'b1;
            cmd.set_valid = accept && !status.item_read && !status.pkt_done;
         end
         rpfs_pkg::ST_FLUSH: begin
            cmd.flush_wr  = 1'b1;
            cmd.cnt_inc   = 1'b1;
            cmd.set_valid = status.cnt_row_last;
         end
         rpfs_pkg::ST_READ: begin
            cmd.cnt_clr   = 1'b1;
            cmd.pix_load  = 1'b1;
            cmd.set_valid = 1'b1;
         end
         default: cmd.cnt_clr = 1'b1;
      endcase
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == rpfs_pkg::ST_CLEAR |-> !req_tready)
      else $error("request accepted during clear sweep");

   a_read_goes_read: assert property (@(posedge clock) disable iff (reset)
      accept && status.item_read |=> state_ff == rpfs_pkg::ST_READ)
      else $error("pixel read did not enter read state");

   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == rpfs_pkg::ST_READ |=> status.rsp_valid)
      else $error("pixel read produced no response");

   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == rpfs_pkg::ST_FLUSH && status.cnt_row_last
      |=> state_ff == rpfs_pkg::ST_IDLE && status.rsp_valid)
      else $error("row flush ended without response");

endmodule

>>> rtl/core/rpfs_dp.sv
// ----------------------------------------------------------------------------
// rpfs_dp
// Datapath: packet parser, row buffer, frame store, rotation, response reg.
// ----------------------------------------------------------------------------
module rpfs_dp #(
   parameter int ROW_BYTES   = 16,
   parameter int FRAME_BYTES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [1:0]           csr_wdata,
   input  logic [23:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,
   input  rpfs_pkg::cmd_type    cmd,
   output rpfs_pkg::status_type status
);

   localparam int AW   = $clog2(FRAME_BYTES);
   localparam int RW   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int CW   = (AW > RW) ? AW : RW;
   localparam int PW   = $clog2(ROW_BYTES + rpfs_pkg::HDR_LEN);
   localparam int SW   = 9 + RW;
   localparam int SUMW = ((SW > CW) ? SW : CW) + 1;
   localparam int IW   = ((8 + RW > AW) ? 8 + RW : AW) + 1;
   localparam int PKT_LEN    = ROW_BYTES + rpfs_pkg::HDR_LEN;
   localparam bit REDIRECT   = FRAME_BYTES >= ROW_BYTES;
   localparam int LAST_START = REDIRECT ? FRAME_BYTES - ROW_BYTES : 0;

   // request fields
   logic       action;
   logic [7:0] rx_byte;
   logic [6:0] pix_x;
   logic [5:0] pix_y;

   assign action  = req_tuser;
   assign rx_byte = req_tdata[7:0];
   assign pix_x   = req_tdata[14:8];
   assign pix_y   = req_tdata[20:15];

   logic [1:0]    rotation_ff;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    row_number_ff, row_number_in;
   logic          seen_row_ff, seen_row_in;
   logic [SW-1:0] start_ff, start_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    row_store_ff [ROW_BYTES];

   logic          byte_take;
   logic          pkt_done;
   logic [PW-1:0] row_idx_full;
   logic [RW-1:0] row_idx;
   logic [SW-1:0] start_raw;

   assign byte_take    = cmd.accept && !action;
   assign pkt_done     = !action && (pos_ff == PW'(PKT_LEN - 1));
   assign row_idx_full = pos_ff - PW'(rpfs_pkg::HDR_LEN);
   assign row_idx      = row_idx_full[RW-1:0];
   assign start_raw    = SW'(row_number_ff) * SW'(ROW_BYTES);

   // header hunt and row gathering
   always_comb begin
      pos_in        = pos_ff;
      row_number_in = row_number_ff;
      seen_row_in   = seen_row_ff;
      start_in      = start_ff;
      if (byte_take) begin
         if (pos_ff == PW'(0)) begin
            if (rx_byte == rpfs_pkg::SYNC_CHAR) pos_in = PW'(1);
         end else if (pos_ff == PW'(1)) begin
            pos_in = (rx_byte == rpfs_pkg::COLON_CHAR) ? PW'(2) : PW'(0);
         end else if (pos_ff == PW'(2)) begin
            row_number_in = rx_byte;
            pos_in        = PW'(rpfs_pkg::HDR_LEN);
         end else if (pkt_done) begin
            pos_in      = PW'(0);
            seen_row_in = 1'b1;
            // rows that would run past the end land on row 0
            start_in = (REDIRECT && SUMW'(start_raw) > SUMW'(LAST_START)) ? '0 : start_raw;
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff   <= rpfs_pkg::ROT_0;
         pos_ff        <= '0;
         row_number_ff <= '0;
         seen_row_ff   <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (csr_wen) rotation_ff <= csr_wdata;
         pos_ff        <= pos_in;
         row_number_ff <= row_number_in;
         seen_row_ff   <= seen_row_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      if (byte_take && pos_ff >= PW'(rpfs_pkg::HDR_LEN)) begin
         row_store_ff[row_idx] <= rx_byte;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   // frame store access
   logic [SUMW-1:0] flush_sum;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [7:0]      ram_wdata;
   logic [IW-1:0]   rd_idx;
   logic [7:0]      ram_rdata;

   assign flush_sum = SUMW'(start_ff) + SUMW'(cnt_ff);
   assign rd_idx    = IW'(pix_y) * IW'(ROW_BYTES) + IW'(pix_x[6:3]);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_ff[AW-1:0];
      ram_wdata = '0;
      if (cmd.clear_wr) begin
         ram_we = 1'b1;
      end else if (cmd.flush_wr) begin
         ram_we    = flush_sum < SUMW'(FRAME_BYTES);
         ram_waddr = flush_sum[AW-1:0];
         ram_wdata = row_store_ff[cnt_ff[RW-1:0]];
      end
   end

   rpfs_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // rotation
   logic [6:0] sx, sy;

   always_comb begin
      unique case (rotation_ff)
         rpfs_pkg::ROT_90: begin
            sx = {1'b0, pix_y};
            sy = ~pix_x;
         end
         rpfs_pkg::ROT_180: begin
            sx = ~pix_x;
            sy = {1'b0, ~pix_y};
         end
         rpfs_pkg::ROT_270: begin
            sx = {1'b0, ~pix_y};
            sy = pix_x;
         end
         default: begin
            sx = pix_x;
            sy = {1'b0, pix_y};
         end
      endcase
   end

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       written_ff, link_ff, pixel_ff;
   logic [6:0] sx_ff, sy_ff;
   logic       in_range_ff;
   logic [2:0] xlo_ff;

   assign rsp_valid_in = cmd.set_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         written_ff  <= pkt_done;
         link_ff     <= seen_row_ff || pkt_done;
         sx_ff       <= action ? sx : '0;
         sy_ff       <= action ? sy : '0;
         pixel_ff    <= 1'b0;
         in_range_ff <= rd_idx < IW'(FRAME_BYTES);
         xlo_ff      <= pix_x[2:0];
      end else if (cmd.pix_load) begin
         pixel_ff <= in_range_ff && ram_rdata[3'd7 - xlo_ff];
      end
   end

   assign rsp_tdata = {7'd0, pixel_ff, sy_ff, sx_ff, link_ff, written_ff};

   assign status.item_read      = action;
   assign status.pkt_done       = pkt_done;
   assign status.cnt_row_last   = cnt_ff == CW'(ROW_BYTES - 1);
   assign status.cnt_frame_last = cnt_ff == CW'(FRAME_BYTES - 1);
   assign status.rsp_valid      = rsp_valid_ff;

endmodule

>>> tb/row_packet_frame_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// row_packet_frame_store_tb
// Self-checking bench: link-byte packets and pixel reads with a local predictor.
// ----------------------------------------------------------------------------
// Items stream into req_* and each one is scored against a predicted response
// in order. Directed tests cover the reset image, header hunting and an
// out-of-range row. Random traffic covers well-formed packets, broken ones,
// stray bytes and reads under every rotation. Both channels idle at random.
// ----------------------------------------------------------------------------
module row_packet_frame_store_tb;

   localparam int ROW_BYTES   = 16;
   localparam int FRAME_BYTES = 1024;
   localparam int CYCLE_LIMIT = 400000;  // sweep + worst stalls, many times over

   // item kinds carried on req_tuser
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // body fill patterns for packets
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ALT    = 1;
   localparam int FILL_ZERO   = 2;
   localparam int FILL_ONES   = 3;

   typedef struct {
      logic       row_written;
      logic       link_up;
      logic [6:0] screen_x;
      logic [6:0] screen_y;
      logic       pixel_on;
   } rsp_fields_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_wen    = 1'b0;
   logic [1:0]  csr_wdata  = 2'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = 24'd0;  // rx_byte[7:0], pix_x[14:8], pix_y[20:15]
   logic        req_tuser  = 1'b0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // row_written[0], link_up[1], screen_x[8:2],
                                     // screen_y[15:9], pixel_on[16]

   // predictor state
   int unsigned hunt_pos  = 0;       // 0 hunt 'Y', 1 want ':', 2 row number, 3+ body
   logic [7:0]  row_sel   = 8'd0;
   logic [7:0]  line_buf  [ROW_BYTES];
   logic [7:0]  frame_mem [FRAME_BYTES];
   logic        link_seen = 1'b0;
   logic [1:0]  rot       = rpfs_pkg::ROT_0;

   rsp_fields_type rsp_backlog [$];  // predicted responses, oldest first
   int unsigned items_sent     = 0;
   int unsigned rsp_seen       = 0;
   int unsigned mismatch_count = 0;
   bit          quiet_mode     = 1'b0;  // no idling on either side
   bit          interleave_rd  = 1'b0;  // reads dropped into packet bodies
   logic [5:0]  last_row_y     = 6'd0;  // frame row that the last packet aimed at

   row_packet_frame_store #(
      .ROW_BYTES  (ROW_BYTES),
      .FRAME_BYTES(FRAME_BYTES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < FRAME_BYTES; i++) frame_mem[i] = 8'h00;
      for (int i = 0; i < ROW_BYTES; i++) line_buf[i] = 8'h00;
   end

   // --------------------------------------------------------------------------
   // Predictor: one item in, the response it must produce out.
   // --------------------------------------------------------------------------
   function automatic rsp_fields_type absorb_item(logic act, logic [7:0] b,
                                                  logic [6:0] x, logic [5:0] y);
      rsp_fields_type r;
      int unsigned base;
      int unsigned idx;
      r = '{default: '0};
      if (act == ACT_BYTE) begin
         if (hunt_pos == 0) begin
            if (b == rpfs_pkg::SYNC_CHAR) hunt_pos = 1;
         end else if (hunt_pos == 1) begin
            // a bad second byte drops back to hunting; it is not a new sync
            hunt_pos = (b == rpfs_pkg::COLON_CHAR) ? 2 : 0;
         end else if (hunt_pos == 2) begin
            row_sel  = b;
            hunt_pos = rpfs_pkg::HDR_LEN;
         end else begin
            line_buf[hunt_pos - rpfs_pkg::HDR_LEN] = b;
            hunt_pos++;
            if (hunt_pos == rpfs_pkg::HDR_LEN + ROW_BYTES) begin
               hunt_pos      = 0;
               link_seen     = 1'b1;
               r.row_written = 1'b1;
               base = row_sel * ROW_BYTES;
               if (base > FRAME_BYTES - ROW_BYTES) base = 0;  // row past the end
               for (int i = 0; i < ROW_BYTES; i++)
                  if (base + i < FRAME_BYTES) frame_mem[base + i] = line_buf[i];
            end
         end
      end else begin
         idx = y * ROW_BYTES + x / 8;
         if (idx < FRAME_BYTES) r.pixel_on = frame_mem[idx][7 - x[2:0]];
         case (rot)
            rpfs_pkg::ROT_90: begin
               r.screen_x = {1'b0, y};
               r.screen_y = 7'd127 - x;
            end
            rpfs_pkg::ROT_180: begin
               r.screen_x = 7'd127 - x;
               r.screen_y = 7'd63 - y;
            end
            rpfs_pkg::ROT_270: begin
               r.screen_x = 7'd63 - y;
               r.screen_y = x;
            end
            default: begin
               r.screen_x = x;
               r.screen_y = {1'b0, y};
            end
         endcase
      end
      r.link_up = link_seen;
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Request side. Valid stays high between back-to-back items; a gap lowers it.
   // --------------------------------------------------------------------------
   task automatic send_item(logic act, logic [7:0] b, logic [6:0] x, logic [5:0] y);
      if (!quiet_mode && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {3'b000, y, x, b};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      rsp_backlog.push_back(absorb_item(act, b, x, y));
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      send_item(ACT_BYTE, b, 7'($urandom), 6'($urandom));
   endtask

   task automatic send_read(logic [6:0] x, logic [5:0] y);
      send_item(ACT_READ, 8'($urandom), x, y);
   endtask

   // header, then body_len pixel bytes; a short body leaves the packet open
   task automatic send_packet(logic [7:0] row, int unsigned body_len, int fill,
                              bit bad_colon);
      logic [7:0] b;
      send_byte(rpfs_pkg::SYNC_CHAR);
      if (bad_colon) begin
         b = 8'($urandom);
         if (b == rpfs_pkg::COLON_CHAR) b = 8'h00;
         send_byte(b);
      end else begin
         send_byte(rpfs_pkg::COLON_CHAR);
      end
      send_byte(row);
      last_row_y = (row < 64) ? row[5:0] : 6'd0;
      for (int i = 0; i < body_len; i++) begin
         case (fill)
            FILL_ALT:  b = i[0] ? 8'h00 : 8'hFF;
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default:   b = 8'($urandom);
         endcase
         if (interleave_rd && $urandom_range(99) < 8)
            send_read(7'($urandom), last_row_y);
         send_byte(b);
      end
   endtask

   // hold off the sender until every predicted response has been taken
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (rsp_backlog.size() != 0) @(posedge clock);
      repeat (ROW_BYTES + 4) @(posedge clock);
   endtask

   task automatic set_rotation(logic [1:0] r);
      drain_responses();
      csr_wen   <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_wen   <= 1'b0;
      rot = r;
   endtask

   // --------------------------------------------------------------------------
   // Response side: random back-pressure and in-order scoring.
   // --------------------------------------------------------------------------
   always @(posedge clock)
      rsp_tready <= quiet_mode || ($urandom_range(99) >= 10);

   task automatic flag_field(string field, int want_v, int got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("response %0d: %s expected %0d, got %0d", rsp_seen, field, want_v,
                  got_v);
   endtask

   always @(posedge clock) begin : rsp_checker
      rsp_fields_type want;
      if (reset !== 1'b1 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         rsp_seen++;
         if (rsp_backlog.size() == 0) begin
            flag_field("unexpected transfer", 0, 1);
         end else begin
            want = rsp_backlog.pop_front();
            if (rsp_tdata[0] !== want.row_written)
               flag_field("row_written", want.row_written, rsp_tdata[0]);
            if (rsp_tdata[1] !== want.link_up)
               flag_field("link_up", want.link_up, rsp_tdata[1]);
            if (rsp_tdata[8:2] !== want.screen_x)
               flag_field("screen_x", want.screen_x, rsp_tdata[8:2]);
            if (rsp_tdata[15:9] !== want.screen_y)
               flag_field("screen_y", want.screen_y, rsp_tdata[15:9]);
            if (rsp_tdata[16] !== want.pixel_on)
               flag_field("pixel_on", want.pixel_on, rsp_tdata[16]);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // cleared image, link down
   task automatic test_reset_state();
      send_read(7'd0, 6'd0);
      send_read(7'd127, 6'd63);
   endtask

   // zero byte as a wrong first byte, sync followed by sync, stray colon
   task automatic test_header_hunt();
      send_byte(8'h00);
      send_byte(rpfs_pkg::SYNC_CHAR);
      send_byte(rpfs_pkg::SYNC_CHAR);
      send_byte(rpfs_pkg::COLON_CHAR);
   endtask

   // first row past the end lands on row 0; read both ends of that row
   task automatic test_row_bounds();
      send_packet(8'd64, ROW_BYTES, FILL_ALT, 1'b0);
      send_read(7'd0, 6'd0);
      send_read(7'd127, 6'd0);
   endtask

   task automatic test_random_traffic(int unsigned n_items);
      int unsigned first;
      int unsigned pick;
      logic [7:0]  row;
      logic [6:0]  x;
      logic [5:0]  y;
      first = items_sent;
      interleave_rd = 1'b1;
      while (items_sent - first < n_items) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            case ($urandom_range(3))
               0:       row = 8'($urandom);
               1:       row = 8'($urandom_range(62, 65));
               default: row = 8'($urandom_range(63));
            endcase
            pick = $urandom_range(99);
            if (pick < 6)
               send_packet(row, 0, FILL_RANDOM, 1'b1);  // broken header
            else if (pick < 12)
               send_packet(row, $urandom_range(1, ROW_BYTES - 1), FILL_RANDOM, 1'b0);
            else
               send_packet(row, ROW_BYTES, $urandom_range(7) < 5 ? FILL_RANDOM :
                           $urandom_range(FILL_ALT, FILL_ONES), 1'b0);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) begin
               x = 7'($urandom);
               y = $urandom_range(1) ? last_row_y : 6'($urandom);
               if ($urandom_range(9) == 0) begin
                  x = $urandom_range(1) ? 7'd127 : 7'd0;
                  y = $urandom_range(1) ? 6'd63 : 6'd0;
               end
               send_read(x, y);
            end
         end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end
      end
      interleave_rd = 1'b0;
   endtask

   // walk the rotation register through every code, both extremes included
   task automatic test_rotations();
      test_random_traffic(250);           // reset value
      set_rotation(rpfs_pkg::ROT_270);
      quiet_mode = 1'b1;                  // long stretch with no idling
      test_random_traffic(250);
      quiet_mode = 1'b0;
      set_rotation(rpfs_pkg::ROT_90);
      test_random_traffic(300);
      set_rotation(rpfs_pkg::ROT_180);
      test_random_traffic(300);
      set_rotation(rpfs_pkg::ROT_0);
      test_random_traffic(300);
   endtask

   // run limit
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("row_packet_frame_store_tb NOT OK");
      $finish;
   end

   initial begin : sequencer
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_header_hunt();
      test_row_bounds();
      test_rotations();
      drain_responses();
      if (mismatch_count == 0)
         $display("row_packet_frame_store_tb OK");
      else
         $display("row_packet_frame_store_tb NOT OK");
      $finish;
   end

endmodule
